// ===== design/assert_macros.svh =====
// Assertion macros used by the checker module of the token walker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define AST_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define AST_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== design/fdtw_pkg.sv =====
// Package for the flattened devicetree structure token walker.
// Holds the token codes, phase and event types and the result record; no dependencies.
package fdtw_pkg;

	localparam int MAX_DEPTH = 255;
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
	localparam int WORD_W    = 32;
	localparam int SKIP_W    = 30;
	localparam int OUT_W     = 80;

	localparam logic [WORD_W-1:0] TOK_BEGIN   = 32'd1;
	localparam logic [WORD_W-1:0] TOK_ENDNODE = 32'd2;
	localparam logic [WORD_W-1:0] TOK_PROP    = 32'd3;
	localparam logic [WORD_W-1:0] TOK_NOP     = 32'd4;
	localparam logic [WORD_W-1:0] TOK_END     = 32'd9;

	typedef enum logic [2:0] {
		PH_TOKEN = 3'd0,
		PH_NAME  = 3'd1,
		PH_LEN   = 3'd2,
		PH_OFF   = 3'd3,
		PH_VALUE = 3'd4,
		PH_DONE  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		EV_SKIP      = 3'd0,
		EV_BEGIN     = 3'd1,
		EV_PROP      = 3'd2,
		EV_END_NODE  = 3'd3,
		EV_NOP       = 3'd4,
		EV_END       = 3'd5,
		EV_BAD_TOKEN = 3'd6,
		EV_AFTER_END = 3'd7
	} event_t;

	typedef struct packed {
		logic        depth_error;
		logic [31:0] name_offset;
		logic [31:0] value_len;
		logic [7:0]  depth;
		event_t      event_res;
	} result_t;

	function automatic logic has_zero_byte(input logic [WORD_W-1:0] w);
		return (w[31:24] == 8'd0) || (w[23:16] == 8'd0) ||
			(w[15:8] == 8'd0) || (w[7:0] == 8'd0);
	endfunction

endpackage

// ===== design/fdtw_in_reg.sv =====
// Input register of the token walker: holds one accepted word for the walk stage.
// Depends on fdtw_pkg for the word width.
module fdtw_in_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [fdtw_pkg::WORD_W-1:0] in_word,
	input  logic                       take,
	output logic                       vld_s1,
	output logic [fdtw_pkg::WORD_W-1:0] word_s1
);
	import fdtw_pkg::*;

	// The register may refill in the same cycle as its word moves on.
	assign in_ready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_word;
		end
	end

endmodule

// ===== design/fdtw_walk.sv =====
// Walk stage: phase, nesting depth, skip count and held length, with the event logic.
// Depends on fdtw_pkg for tokens, phases, events and the result record.
module fdtw_walk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic [fdtw_pkg::WORD_W-1:0] word_s1,
	output fdtw_pkg::result_t          res
);
	import fdtw_pkg::*;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

	phase_t              phase_q, phase_d;
	logic [DEPTH_W-1:0]  nest_q, nest_d;
	logic [SKIP_W-1:0]   skip_q, skip_d, skip_dec;
	logic [WORD_W-1:0]   len_q, len_d;
	logic [WORD_W-1:0]   len_round;

	// Rounding up to whole words wraps at 32 bits, as the length adder does.
	assign len_round = len_q + 32'd3;
	assign skip_dec  = (skip_q != '0) ? skip_q - SKIP_W'(1) : skip_q;

	always_comb begin
		phase_d = phase_q;
		nest_d  = nest_q;
		skip_d  = skip_q;
		len_d   = len_q;
		res.event_res   = EV_SKIP;
		res.depth       = 8'(nest_q);
		res.value_len   = '0;
		res.name_offset = '0;
		res.depth_error = 1'b0;
		unique case (phase_q)
			PH_NAME: begin
				if (has_zero_byte(word_s1)) begin
					phase_d = PH_TOKEN;
				end
			end
			PH_LEN: begin
				len_d   = word_s1;
				phase_d = PH_OFF;
			end
			PH_OFF: begin
				res.event_res   = EV_PROP;
				res.value_len   = len_q;
				res.name_offset = word_s1;
				skip_d          = len_round[31:2];
				phase_d         = (len_round[31:2] != '0) ? PH_VALUE : PH_TOKEN;
			end
			PH_VALUE: begin
				skip_d = skip_dec;
				if (skip_dec == '0) begin
					phase_d = PH_TOKEN;
				end
			end
			PH_DONE: begin
				res.event_res = EV_AFTER_END;
			end
			PH_TOKEN: begin
				priority if (word_s1 == TOK_BEGIN) begin
					res.event_res = EV_BEGIN;
					if (nest_q >= DEPTH_MAX) begin
						nest_d          = DEPTH_MAX;
						res.depth_error = 1'b1;
					end else begin
						nest_d = nest_q + DEPTH_W'(1);
					end
					phase_d = PH_NAME;
				end else if (word_s1 == TOK_ENDNODE) begin
					res.event_res = EV_END_NODE;
					if (nest_q == '0) begin
						res.depth_error = 1'b1;
					end else begin
						nest_d    = nest_q - DEPTH_W'(1);
						res.depth = 8'(nest_q - DEPTH_W'(1));
					end
				end else if (word_s1 == TOK_PROP) begin
					phase_d = PH_LEN;
				end else if (word_s1 == TOK_NOP) begin
					res.event_res = EV_NOP;
				end else if (word_s1 == TOK_END) begin
					res.event_res = EV_END;
					phase_d       = PH_DONE;
				end else begin
					res.event_res = EV_BAD_TOKEN;
				end
			end
			default: begin
				res.event_res = EV_BAD_TOKEN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOKEN;
			nest_q  <= '0;
			skip_q  <= '0;
			len_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			nest_q  <= nest_d;
			skip_q  <= skip_d;
			len_q   <= len_d;
		end
	end

endmodule

// ===== design/fdt_struct_token_walker_unit.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   32     structure-block word, first byte in bits 31:24
// m_axis    out  80     event_res, depth, value_len, name_offset, depth_error
//
// Each word gives exactly one result. A word is held in the input register and is
// resolved by the walk stage into the result register; one word per cycle is sustained
// while m_axis is not stalled. arst_n clears the phase, depth, skip count, held length
// and both valid flags. A stall on m_axis holds the result register; the input
// register keeps taking words until it too is full.
// Top level of the token walker; uses fdtw_pkg, fdtw_in_reg and fdtw_walk.
module fdt_struct_token_walker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata   // [2:0] event_res, [10:3] depth, [42:11] value_len,
	                                   // [74:43] name_offset, [75] depth_error, rest zero
);
	import fdtw_pkg::*;

	logic              vld_s1;
	logic [WORD_W-1:0] word_s1;
	logic              take;
	result_t           res;
	logic              vld_s2;
	result_t           res_s2;

	// A word leaves the input register whenever the result register is free or draining.
	assign take = vld_s1 && (!vld_s2 || m_axis_tready);

	fdtw_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_word  (s_axis_tdata),
		.take     (take),
		.vld_s1   (vld_s1),
		.word_s1  (word_s1)
	);

	fdtw_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.word_s1 (word_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (take) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = OUT_W'(res_s2);

endmodule

// ===== design/fdtw_checker.sv =====
// Port-level checker for the token walker, bound to the top level.
// Depends on fdtw_pkg for event codes and on assert_macros.svh.
`include "assert_macros.svh"

module fdtw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata
);
	import fdtw_pkg::*;

	logic   out_xfer;
	event_t ev;
	logic   seen_end_q;

	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign ev       = event_t'(m_axis_tdata[2:0]);

	// Remembers that the end token has been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_end_q <= 1'b0;
		end else if (out_xfer && ev == EV_END) begin
			seen_end_q <= 1'b1;
		end
	end

	`AST_ALWAYS(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "result changed while stalled")
	`AST_NEVER(a_prop_fields, m_axis_tvalid && ev != EV_PROP && m_axis_tdata[74:11] != 64'd0, "length or offset outside a property event")
	`AST_NEVER(a_derr_event, m_axis_tvalid && m_axis_tdata[75] && ev != EV_BEGIN && ev != EV_END_NODE, "depth error on a non-node event")
	`AST_NEVER(a_after_end, out_xfer && seen_end_q && ev != EV_AFTER_END, "event other than after-end once the tree has ended")

endmodule

bind fdt_struct_token_walker_unit fdtw_checker u_fdtw_checker (.*);
